### hdl/cbtd_pkg.sv
// shared types and constants for the compressed block texel decoder
`timescale 1ns / 1ps

package cbtd_pkg;

    localparam int unsigned S_DATA_W = 64;
    localparam int unsigned M_DATA_W = 40;
    localparam logic [7:0]  FULL_ALPHA = 8'hFF;
    localparam logic [7:0]  ZERO_ALPHA = 8'h00;
    localparam logic [3:0]  LAST_PIX   = 4'hF;

    // decoded palette and index rows of one block
    typedef struct packed {
        logic [3:0][31:0] palette;
        logic [3:0][7:0]  rows;
    } blk_t;

endpackage

### hdl/cbtd_front.sv
// front end: accepts a compressed block beat and builds its four-color palette
`timescale 1ns / 1ps

module cbtd_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [cbtd_pkg::S_DATA_W-1:0]     s_axis_tdata,
    output logic                              blk_valid,
    input  logic                              blk_ready,
    output cbtd_pkg::blk_t                    blk_data
);
    import cbtd_pkg::*;

    logic        front_valid_reg;
    logic        front_valid_next;
    blk_t        front_blk_reg;
    blk_t        front_blk_next;
    logic [15:0] c0;
    logic [15:0] c1;
    logic        gt;
    logic [15:0] mix_r;
    logic [15:0] mix_g;
    logic [15:0] mix_b;
    logic [7:0]  r0, g0, b0, r1, g1, b1;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    // returns {entry3, entry2} for one channel
    function automatic logic [15:0] chan_mix(input logic [7:0] a, input logic [7:0] b,
                                             input logic sel_gt);
        logic signed [8:0] d;
        logic signed [8:0] st;
        logic [8:0]        p2;
        logic [8:0]        p3;
        logic [8:0]        avg;
        d   = $signed({1'b0, b}) - $signed({1'b0, a});
        st  = (d >>> 1) - (d >>> 3);
        p2  = {1'b0, a} + st;
        p3  = {1'b0, b} - st;
        avg = ({1'b0, a} + {1'b0, b} + 9'd1) >> 1;
        if (sel_gt) begin
            return {p3[7:0], p2[7:0]};
        end
        return {b, avg[7:0]};
    endfunction

    assign c0 = s_axis_tdata[15:0];
    assign c1 = s_axis_tdata[31:16];
    assign gt = c0 > c1;
    assign r0 = widen5(c0[15:11]);
    assign g0 = widen6(c0[10:5]);
    assign b0 = widen5(c0[4:0]);
    assign r1 = widen5(c1[15:11]);
    assign g1 = widen6(c1[10:5]);
    assign b1 = widen5(c1[4:0]);
    assign mix_r = chan_mix(r0, r1, gt);
    assign mix_g = chan_mix(g0, g1, gt);
    assign mix_b = chan_mix(b0, b1, gt);

    assign s_axis_tready = !front_valid_reg || blk_ready;
    assign blk_valid     = front_valid_reg;
    assign blk_data      = front_blk_reg;

    always_comb begin
        front_valid_next = front_valid_reg;
        front_blk_next   = front_blk_reg;
        if (blk_ready) begin
            front_valid_next = 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            front_valid_next          = 1'b1;
            front_blk_next.palette[0] = {FULL_ALPHA, b0, g0, r0};
            front_blk_next.palette[1] = {FULL_ALPHA, b1, g1, r1};
            front_blk_next.palette[2] = {FULL_ALPHA, mix_b[7:0], mix_g[7:0], mix_r[7:0]};
            front_blk_next.palette[3] = {(gt ? FULL_ALPHA : ZERO_ALPHA),
                                         mix_b[15:8], mix_g[15:8], mix_r[15:8]};
            front_blk_next.rows[0]    = s_axis_tdata[39:32];
            front_blk_next.rows[1]    = s_axis_tdata[47:40];
            front_blk_next.rows[2]    = s_axis_tdata[55:48];
            front_blk_next.rows[3]    = s_axis_tdata[63:56];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
        front_blk_reg <= front_blk_next;
    end

endmodule

### hdl/cbtd_queue.sv
// two-entry block queue between front end and pixel sequencer
`timescale 1ns / 1ps

module cbtd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  cbtd_pkg::blk_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output cbtd_pkg::blk_t out_data
);
    import cbtd_pkg::*;

    blk_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### hdl/cbtd_back.sv
// back end: walks the sixteen texels of the queued block into the output register
`timescale 1ns / 1ps

module cbtd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          blk_valid,
    output logic                          blk_ready,
    input  cbtd_pkg::blk_t                blk_data,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [cbtd_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast
);
    import cbtd_pkg::*;

    logic [3:0]          cnt_reg;
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_last_reg;
    logic                load;
    logic [7:0]          row_bits;
    logic [1:0]          idx;

    assign load      = blk_valid && (!m_valid_reg || m_axis_tready);
    assign blk_ready = load && (cnt_reg == LAST_PIX);
    assign row_bits  = blk_data.rows[cnt_reg[3:2]];

    // column 0 sits in the top bits of the row byte
    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    idx = row_bits[7:6];
            2'd1:    idx = row_bits[5:4];
            2'd2:    idx = row_bits[3:2];
            default: idx = row_bits[1:0];
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                cnt_reg     <= cnt_reg + 4'd1;
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (load) begin
            m_data_reg <= {4'd0, cnt_reg[3:2], cnt_reg[1:0], blk_data.palette[idx]};
            m_last_reg <= cnt_reg == LAST_PIX;
        end
    end

endmodule

### hdl/compressed_block_texel_decode.sv
// top level of the compressed 4x4 block texel decoder
//
// input stream: one beat per 8-byte compressed block, two RGB565 endpoints and
// four rows of 2-bit indices. output stream: sixteen beats per block, one texel
// each, row 0 first and column 0 first, tlast on the sixteenth.
// the front end builds the four-entry palette and registers it; a two-entry
// queue holds finished palettes; the back end steps a 4-bit texel counter and
// loads the output register.
// the block passes the front-end register and the queue before the back end
// loads its first texel. throughput: one texel per cycle while a block is queued
// and m_axis_tready is high, set by the texel counter in the back end. up to three
// blocks may be held in flight, so the input keeps taking beats while the output drains.
// reset: aresetn low clears the queue, the counter and all valid flags; any
// block in flight is dropped.
// stall: with m_axis_tready low the current texel beat holds; the queue fills
// and then s_axis_tready drops until room frees up.
`timescale 1ns / 1ps

module compressed_block_texel_decode (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // first_color[15:0], second_color[31:16], row0_indices[39:32],
    // row1_indices[47:40], row2_indices[55:48], row3_indices[63:56]
    input  logic [cbtd_pkg::S_DATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pixel_rgba[31:0], pixel_column[33:32], pixel_row[35:34], zero[39:36]
    output logic [cbtd_pkg::M_DATA_W-1:0] m_axis_tdata,
    // last_pixel
    output logic                          m_axis_tlast
);
    import cbtd_pkg::*;

    logic front_valid;
    logic front_ready;
    blk_t front_blk;
    logic queue_valid;
    logic queue_ready;
    blk_t queue_blk;

    cbtd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .blk_valid     (front_valid),
        .blk_ready     (front_ready),
        .blk_data      (front_blk)
    );

    cbtd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_blk),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_data  (queue_blk)
    );

    cbtd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .blk_valid     (queue_valid),
        .blk_ready     (queue_ready),
        .blk_data      (queue_blk),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### hdl/cbtd_checker.sv
// port-level checks for the texel decoder and their bind to the top level
`timescale 1ns / 1ps

module cbtd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [cbtd_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tlast
);
    import cbtd_pkg::*;

    // output beat holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    // tlast only on the bottom-right texel
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[35:32] == LAST_PIX)))
        else $error("tlast does not match texel position");

    // padding bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[39:36] == 4'd0))
        else $error("padding bits set");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind compressed_block_texel_decode cbtd_checker u_cbtd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### verif/tb_compressed_block_texel_decode.sv
// testbench for the compressed block texel decoder: directed and random blocks checked texel by texel
`timescale 1ns / 1ps

module tb_compressed_block_texel_decode;

    import cbtd_pkg::*;

    typedef struct packed {
        logic [31:0] rgba;
        logic [1:0]  col;
        logic [1:0]  row;
        logic        last;
    } texel_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tlast;

    texel_t texel_q[$];
    int     err_count = 0;
    int     src_idle_pct = 0;
    int     sink_idle_pct = 0;

    compressed_block_texel_decode dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int widen5(logic [4:0] v);
        return int'({v, v[4:2]});
    endfunction

    function automatic int widen6(logic [5:0] v);
        return int'({v, v[5:4]});
    endfunction

    // signed step toward the other endpoint, floor shifts
    function automatic int blend_step(int from, int to);
        int d;
        d = to - from;
        return (d >>> 1) - (d >>> 3);
    endfunction

    function automatic logic [31:0] pack_rgba(int r, int g, int b, logic [7:0] a);
        return {a, b[7:0], g[7:0], r[7:0]};
    endfunction

    task automatic predict_texels(input logic [15:0] c0, input logic [15:0] c1,
                                  input logic [31:0] rows);
        int r0, g0, b0, r1, g1, b1, dr, dg, db;
        logic [31:0] pal [4];
        logic [1:0]  idx;
        texel_t      t;
        r0 = widen5(c0[15:11]);
        g0 = widen6(c0[10:5]);
        b0 = widen5(c0[4:0]);
        r1 = widen5(c1[15:11]);
        g1 = widen6(c1[10:5]);
        b1 = widen5(c1[4:0]);
        pal[0] = pack_rgba(r0, g0, b0, FULL_ALPHA);
        pal[1] = pack_rgba(r1, g1, b1, FULL_ALPHA);
        if (c0 > c1) begin
            dr = blend_step(r0, r1);
            dg = blend_step(g0, g1);
            db = blend_step(b0, b1);
            pal[2] = pack_rgba(r0 + dr, g0 + dg, b0 + db, FULL_ALPHA);
            pal[3] = pack_rgba(r1 - dr, g1 - dg, b1 - db, FULL_ALPHA);
        end else begin
            pal[2] = pack_rgba((r0 + r1 + 1) / 2, (g0 + g1 + 1) / 2, (b0 + b1 + 1) / 2,
                               FULL_ALPHA);
            pal[3] = pack_rgba(r1, g1, b1, ZERO_ALPHA);
        end
        for (int row = 0; row < 4; row++) begin
            for (int col = 0; col < 4; col++) begin
                idx    = rows[row * 8 + 6 - 2 * col +: 2];
                t.rgba = pal[idx];
                t.col  = col[1:0];
                t.row  = row[1:0];
                t.last = (row == 3) && (col == 3);
                texel_q.push_back(t);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
        err_count++;
    endtask

    // rows holds row0 in the low byte, as on the bus
    task automatic send_block(input logic [15:0] c0, input logic [15:0] c1,
                              input logic [31:0] rows);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {rows, c1, c0};
        do @(posedge aclk); while (!s_axis_tready);
        predict_texels(c0, c1, rows);
    endtask

    initial m_axis_tready = 1'b0;

    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        texel_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (texel_q.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata[31:0], 32'h0);
            end else begin
                want = texel_q.pop_front();
                if (m_axis_tdata[31:0] !== want.rgba)
                    report_mismatch("pixel_rgba", m_axis_tdata[31:0], want.rgba);
                if (m_axis_tdata[33:32] !== want.col)
                    report_mismatch("pixel_column", 32'(m_axis_tdata[33:32]),
                                    32'(want.col));
                if (m_axis_tdata[35:34] !== want.row)
                    report_mismatch("pixel_row", 32'(m_axis_tdata[35:34]),
                                    32'(want.row));
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_pixel", 32'(m_axis_tlast), 32'(want.last));
            end
        end
    end

    // four-color branch and average branch at channel extremes
    task automatic test_endpoint_extremes();
        send_block(16'hFFFF, 16'h0000, 32'h1B1B_1B1B);
        send_block(16'h0000, 16'hFFFF, 32'hE4E4_E4E4);
        send_block(16'hF800, 16'h07FF, 32'h1BE4_1BE4);
        send_block(16'h07FF, 16'hF800, 32'hE41B_E41B);
        send_block(16'hF81F, 16'h07E0, 32'h1B1B_E4E4);
        send_block(16'h07E0, 16'h001F, 32'hE4E4_1B1B);
        send_block(16'h8000, 16'h7FFF, 32'h1B1B_1B1B);
        send_block(16'h7FFF, 16'h8000, 32'h1B1B_1B1B);
        send_block(16'h0001, 16'h0000, 32'hFFAA_5500);
    endtask

    // equal endpoints take the average branch
    task automatic test_equal_endpoints();
        send_block(16'h0000, 16'h0000, 32'h1B1B_1B1B);
        send_block(16'hFFFF, 16'hFFFF, 32'hE4E4_E4E4);
        send_block(16'hA5C3, 16'hA5C3, 32'h1BE4_1BE4);
    endtask

    // one index value across a whole block, then mixed per row
    task automatic test_index_order();
        send_block(16'hC618, 16'h39E7, 32'h0000_0000);
        send_block(16'hC618, 16'h39E7, 32'h5555_5555);
        send_block(16'hC618, 16'h39E7, 32'hAAAA_AAAA);
        send_block(16'hC618, 16'h39E7, 32'hFFFF_FFFF);
        send_block(16'h39E7, 16'hC618, 32'hFFAA_5500);
        send_block(16'h39E7, 16'hC618, 32'h0055_AAFF);
    endtask

    task automatic test_random_blocks(input int count);
        logic [15:0] c0, c1;
        logic [31:0] rows;
        for (int i = 0; i < count; i++) begin
            c0   = 16'($urandom);
            c1   = 16'($urandom);
            rows = $urandom;
            case ($urandom_range(9))
                0: c1 = c0;
                1: c1 = c0 - 16'($urandom_range(1, 3));
                2: c1 = c0 + 16'($urandom_range(1, 3));
                default: ;
            endcase
            send_block(c0, c1, rows);
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        src_idle_pct  = 30;
        sink_idle_pct = 62;
        test_endpoint_extremes();
        test_equal_endpoints();
        test_index_order();
        test_random_blocks(94);

        src_idle_pct  = 62;
        sink_idle_pct = 30;
        test_random_blocks(93);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_blocks(93);

        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (texel_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
hdl/cbtd_pkg.sv
hdl/cbtd_front.sv
hdl/cbtd_queue.sv
hdl/cbtd_back.sv
hdl/compressed_block_texel_decode.sv
hdl/cbtd_checker.sv
verif/tb_compressed_block_texel_decode.sv
